// File: design/vdlp_pkg.sv
// Shared constants, types and state codes for the vector display list processor.
`default_nettype none
package vdlp_pkg;
  localparam int STACK_DEPTH = 8;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W      = $clog2(STACK_DEPTH);
  localparam int MAX_FETCH   = 32768;
  localparam int FC_W        = $clog2(MAX_FETCH + 2);

  localparam logic [15:0] FILL_LONG  = 16'h4000;
  localparam logic [15:0] FILL_SHORT = 16'h4080;
  localparam logic [31:0] BASE_VCTR  = 32'd64 + 32'h8000;
  localparam logic [31:0] BASE_SVEC  = 32'd48 + 32'h100;
  localparam logic [31:0] BASE_CNTR  = 32'd40 + 32'h8000;
  localparam logic [31:0] CYC_STAT   = 32'd56;
  localparam logic [31:0] CYC_JSRL   = 32'd40;
  localparam logic [31:0] CYC_RTSL   = 32'd32;
  localparam logic [31:0] CYC_JMPL   = 32'd24;
  localparam logic [31:0] CYC_HALT   = 32'd16;
  localparam logic [31:0] CYC_START  = 32'd8;
  localparam logic [4:0]  NORM_MAX   = 5'd16;

  typedef enum logic [2:0] {
    OP_VCTR = 3'd0, OP_HALT = 3'd1, OP_SVEC = 3'd2, OP_STAT = 3'd3,
    OP_CNTR = 3'd4, OP_JSRL = 3'd5, OP_RTSL = 3'd6, OP_JMPL = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    STOP_RUN = 3'd0, STOP_HALT = 3'd1, STOP_JZERO = 3'd2, STOP_SOVER = 3'd3,
    STOP_SUNDER = 3'd4, STOP_BADFETCH = 3'd5, STOP_RUNAWAY = 3'd6
  } stop_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_BIN, ST_MUL, ST_ADD, ST_DONE
  } st_e;

  typedef struct packed {
    logic        is_start;
    logic [12:0] start_addr;
    logic [15:0] word;
    op_e         op;
  } cmd_t;
endpackage
`default_nettype wire

// File: design/vdlp_in_if.sv
// Input channel: start or fetched-word transfers.
`default_nettype none
interface vdlp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [12:0] start_addr;
  logic [15:0] word;
  modport source (output valid, action, start_addr, word, input ready);
  modport sink (input valid, action, start_addr, word, output ready);
endinterface
`default_nettype wire

// File: design/vdlp_out_if.sv
// Output channel: one result transfer per input item.
`default_nettype none
interface vdlp_out_if;
  logic               valid;
  logic               ready;
  logic        [12:0] fetch_addr;
  logic               seg_valid;
  logic signed [31:0] seg_x0;
  logic signed [31:0] seg_y0;
  logic signed [31:0] seg_x1;
  logic signed [31:0] seg_y1;
  logic        [2:0]  seg_color;
  logic        [3:0]  seg_lum;
  logic        [2:0]  stop_reason;
  logic        [15:0] words_walked;
  logic        [31:0] frame_cycles;
  logic               rom_warn;
  modport source (output valid, fetch_addr, seg_valid, seg_x0, seg_y0, seg_x1, seg_y1,
                  seg_color, seg_lum, stop_reason, words_walked, frame_cycles, rom_warn,
                  input ready);
  modport sink (input valid, fetch_addr, seg_valid, seg_x0, seg_y0, seg_x1, seg_y1,
                seg_color, seg_lum, stop_reason, words_walked, frame_cycles, rom_warn,
                output ready);
endinterface
`default_nettype wire

// File: design/vdlp_front.sv
// Front end: takes input transfers and classifies them into commands.
`default_nettype none
module vdlp_front
  import vdlp_pkg::*;
(
  vdlp_in_if.sink    in_i,
  input  wire logic  full_i,
  output cmd_t       cmd_o,
  output logic       push_o
);
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    cmd_o.is_start   = !in_i.action;
    cmd_o.start_addr = in_i.start_addr;
    cmd_o.word       = in_i.word;
    cmd_o.op         = op_e'(in_i.word[15:13]);
  end
endmodule
`default_nettype wire

// File: design/vdlp_queue.sv
// Two-entry command queue between front and back.
`default_nettype none
module vdlp_queue
  import vdlp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      empty_o
);
  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

// File: design/vdlp_back.sv
// Back end: executes commands, times vectors, moves the beam, registers results.
`default_nettype none
module vdlp_back
  import vdlp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire logic  cmd_valid_i,
  output logic       cmd_pop_o,
  vdlp_out_if.source out_o
);
  st_e state_q, state_d;

  logic [12:0]        pc_q;
  logic [12:0]        stack_q [STACK_DEPTH];
  logic [SP_W-1:0]    sp_q;
  logic signed [31:0] bx_q, by_q, x0_q, y0_q;
  logic [7:0]         ls_q;
  logic [2:0]         bs_q, col_q;
  logic [3:0]         si_q, lum_q;
  logic [15:0]        pend_q;
  logic               swd_q, run_q, rom_q, seg_q, chk_run_q, chk_fetch_q;
  logic [FC_W-1:0]    fc_q;
  logic [31:0]        cc_q, base_q;
  logic [2:0]         stop_q, z_q, nbin_q;
  logic [12:0]        ny_q, nx_q;
  logic signed [12:0] dx_q, dy_q;
  logic [4:0]         ncnt_q;
  logic [15:0]        t_q;
  logic               short_q;
  logic signed [28:0] px_q, py_q;

  logic [12:0]        pc_inc;
  logic [12:0]        w_addr;
  logic [15:0]        fill, t_sh;
  logic               norm_end;
  logic [14:0]        mulf;
  logic signed [33:0] sum_x, sum_y;
  logic               out_free;
  logic               ni_halt6, ni_halt5, ni_rom;

  assign pc_inc   = pc_q + 13'd1;
  assign w_addr   = cmd_i.word[12:0];
  assign fill     = short_q ? FILL_SHORT : FILL_LONG;
  assign t_sh     = (t_q >> 1) | fill;
  assign norm_end = (ny_q[12] != ny_q[11]) || (nx_q[12] != nx_q[11]) || (ncnt_q == NORM_MAX);
  assign mulf     = {7'd0, ls_q} << (3'd7 - bs_q);
  assign sum_x    = {{2{bx_q[31]}}, bx_q} + {{5{px_q[28]}}, px_q};
  assign sum_y    = {{2{by_q[31]}}, by_q} + {{5{py_q[28]}}, py_q};
  assign out_free = !out_o.valid || out_o.ready;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  // next-instruction checks, applied when the item finishes
  assign ni_halt6 = run_q && chk_run_q && (fc_q >= FC_W'(MAX_FETCH));
  assign ni_halt5 = run_q && chk_fetch_q && !ni_halt6 && pc_q[12];
  assign ni_rom   = run_q && chk_fetch_q && !ni_halt6 && !pc_q[12] && (pc_q[11:10] == 2'b01);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (!cmd_i.is_start && run_q && (swd_q || cmd_i.op == OP_SVEC ||
              cmd_i.op == OP_CNTR)) state_d = ST_NORM;
          else state_d = ST_DONE;
        end
      end
      ST_NORM: if (norm_end) state_d = ST_BIN;
      ST_BIN:  if (nbin_q == 3'd0) state_d = seg_q ? ST_MUL : ST_DONE;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i && !cmd_i.is_start && run_q && !swd_q &&
        cmd_i.op == OP_JSRL && w_addr != 13'd0 && sp_q < SP_W'(STACK_DEPTH - 1))
      stack_q[sp_q[SIDX_W-1:0]] <= pc_inc;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      px_q <= dx_q * $signed({1'b0, mulf});
      py_q <= dy_q * $signed({1'b0, mulf});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q <= '0; sp_q <= '0; bx_q <= '0; by_q <= '0; x0_q <= '0; y0_q <= '0;
      ls_q <= '0; bs_q <= '0; col_q <= '0; si_q <= '0; lum_q <= '0; pend_q <= '0;
      swd_q <= 1'b0; run_q <= 1'b0; rom_q <= 1'b0; seg_q <= 1'b0;
      chk_run_q <= 1'b0; chk_fetch_q <= 1'b0;
      fc_q <= '0; cc_q <= '0; base_q <= '0; stop_q <= STOP_RUN; z_q <= '0; nbin_q <= '0;
      ny_q <= '0; nx_q <= '0; dx_q <= '0; dy_q <= '0; ncnt_q <= '0; t_q <= '0;
      short_q <= 1'b0;
      out_o.valid <= 1'b0;
      out_o.fetch_addr <= '0; out_o.seg_valid <= 1'b0;
      out_o.seg_x0 <= '0; out_o.seg_y0 <= '0; out_o.seg_x1 <= '0; out_o.seg_y1 <= '0;
      out_o.seg_color <= '0; out_o.seg_lum <= '0; out_o.stop_reason <= '0;
      out_o.words_walked <= '0; out_o.frame_cycles <= '0; out_o.rom_warn <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) out_o.valid <= 1'b1;
      else if (out_o.ready) out_o.valid <= 1'b0;
      case (state_q)
        ST_IDLE: if (cmd_valid_i) begin
          seg_q <= 1'b0; chk_run_q <= 1'b0; chk_fetch_q <= 1'b0;
          ncnt_q <= '0; t_q <= '0;
          if (cmd_i.is_start) begin
            pc_q <= cmd_i.start_addr; sp_q <= '0; bx_q <= '0; by_q <= '0;
            ls_q <= '0; bs_q <= '0; si_q <= '0; col_q <= '0; pend_q <= '0;
            swd_q <= 1'b0; fc_q <= '0; cc_q <= CYC_START; rom_q <= 1'b0;
            stop_q <= STOP_RUN; run_q <= 1'b1; chk_run_q <= 1'b1; chk_fetch_q <= 1'b1;
          end else if (run_q) begin
            pc_q <= pc_inc;
            fc_q <= fc_q + FC_W'(1);
            if (swd_q) begin
              swd_q <= 1'b0;
              ny_q <= pend_q[12:0]; nx_q <= w_addr;
              dy_q <= $signed(pend_q[12:0]); dx_q <= $signed(w_addr);
              z_q <= cmd_i.word[15:13]; short_q <= 1'b0; base_q <= BASE_VCTR;
              nbin_q <= bs_q; seg_q <= 1'b1;
            end else begin
              case (cmd_i.op)
                OP_VCTR: begin
                  pend_q <= cmd_i.word; swd_q <= 1'b1; chk_fetch_q <= 1'b1;
                end
                OP_SVEC: begin
                  dx_q <= {{7{cmd_i.word[4]}}, cmd_i.word[4:0], 1'b0};
                  dy_q <= {{7{cmd_i.word[12]}}, cmd_i.word[12:8], 1'b0};
                  z_q <= cmd_i.word[7:5];
                  ny_q <= {cmd_i.word[12:8], 8'd0}; nx_q <= {cmd_i.word[4:0], 8'd0};
                  short_q <= 1'b1; base_q <= BASE_SVEC; nbin_q <= bs_q; seg_q <= 1'b1;
                end
                OP_STAT: begin
                  cc_q <= cc_q + CYC_STAT;
                  if (cmd_i.word[12]) begin
                    bs_q <= cmd_i.word[10:8]; ls_q <= ~cmd_i.word[7:0];
                  end else begin
                    si_q <= cmd_i.word[7:4]; col_q <= cmd_i.word[2:0];
                  end
                  chk_run_q <= 1'b1; chk_fetch_q <= 1'b1;
                end
                OP_CNTR: begin
                  ny_q <= {5'd0, cmd_i.word[7:0]}; nx_q <= '0;
                  short_q <= 1'b0; base_q <= BASE_CNTR; nbin_q <= '0;
                  bx_q <= '0; by_q <= '0; chk_run_q <= 1'b1; chk_fetch_q <= 1'b1;
                end
                OP_JSRL: begin
                  cc_q <= cc_q + CYC_JSRL;
                  if (w_addr == 13'd0) begin
                    run_q <= 1'b0; stop_q <= STOP_JZERO;
                  end else if (sp_q >= SP_W'(STACK_DEPTH - 1)) begin
                    run_q <= 1'b0; stop_q <= STOP_SOVER;
                  end else begin
                    sp_q <= sp_q + SP_W'(1); pc_q <= w_addr;
                    chk_run_q <= 1'b1; chk_fetch_q <= 1'b1;
                  end
                end
                OP_RTSL: begin
                  cc_q <= cc_q + CYC_RTSL;
                  if (sp_q == '0 || sp_q > SP_W'(STACK_DEPTH)) begin
                    run_q <= 1'b0; stop_q <= STOP_SUNDER;
                  end else begin
                    sp_q <= sp_q - SP_W'(1);
                    pc_q <= stack_q[SIDX_W'(sp_q - SP_W'(1))];
                    chk_run_q <= 1'b1; chk_fetch_q <= 1'b1;
                  end
                end
                OP_JMPL: begin
                  cc_q <= cc_q + CYC_JMPL;
                  if (w_addr == 13'd0) begin
                    run_q <= 1'b0; stop_q <= STOP_JZERO;
                  end else begin
                    pc_q <= w_addr; chk_run_q <= 1'b1; chk_fetch_q <= 1'b1;
                  end
                end
                default: begin
                  cc_q <= cc_q + CYC_HALT; run_q <= 1'b0; stop_q <= STOP_HALT;
                end
              endcase
            end
          end
        end
        ST_NORM: begin
          if (norm_end) begin
            if (short_q) t_q <= {8'd0, t_q[7:0]};
          end else begin
            ncnt_q <= ncnt_q + 5'd1;
            ny_q <= {ny_q[12], ny_q[10:0], 1'b0};
            nx_q <= {nx_q[12], nx_q[10:0], 1'b0};
            t_q <= t_sh;
          end
        end
        ST_BIN: begin
          if (nbin_q == 3'd0) begin
            cc_q <= cc_q + base_q - {16'd0, (short_q ? {8'd0, t_q[7:0]} : t_q)};
          end else begin
            nbin_q <= nbin_q - 3'd1;
            t_q <= t_sh;
          end
        end
        ST_ADD: begin
          x0_q <= bx_q; y0_q <= by_q;
          bx_q <= sat32(sum_x); by_q <= sat32(sum_y);
          lum_q <= (z_q == 3'd1) ? si_q : {z_q, 1'b0};
          chk_run_q <= 1'b1; chk_fetch_q <= 1'b1;
        end
        ST_DONE: if (out_free) begin
          if (ni_halt6) begin
            run_q <= 1'b0; stop_q <= STOP_RUNAWAY;
          end else if (ni_halt5) begin
            run_q <= 1'b0; stop_q <= STOP_BADFETCH;
          end
          if (ni_rom) rom_q <= 1'b1;
          out_o.fetch_addr   <= pc_q;
          out_o.seg_valid    <= seg_q;
          out_o.seg_x0       <= seg_q ? x0_q : '0;
          out_o.seg_y0       <= seg_q ? y0_q : '0;
          out_o.seg_x1       <= seg_q ? bx_q : '0;
          out_o.seg_y1       <= seg_q ? by_q : '0;
          out_o.seg_color    <= seg_q ? col_q : '0;
          out_o.seg_lum      <= seg_q ? lum_q : '0;
          out_o.stop_reason  <= ni_halt6 ? STOP_RUNAWAY : (ni_halt5 ? STOP_BADFETCH : stop_q);
          out_o.words_walked <= (fc_q > FC_W'(16'hFFFF)) ? 16'hFFFF : fc_q[15:0];
          out_o.frame_cycles <= cc_q;
          out_o.rom_warn     <= rom_q || ni_rom;
        end
        default: ;
      endcase
    end
  end

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH - 1)) else $error("stack pointer out of range");
  a_norm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncnt_q <= NORM_MAX) else $error("normalizer overran");
  a_done_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (state_q == ST_IDLE && out_o.valid))
    else $error("result not issued");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> state_q != ST_IDLE) else $error("command taken without work");
endmodule
`default_nettype wire

// File: design/vector_display_list_processor_unit.sv
// Top level of the vector display list processor: front, queue and back.
// Path: a start or non-drawing word runs queue, ST_IDLE, ST_DONE, output register; a CNTR adds
// ST_NORM (n shifts, 0..16) and ST_BIN; a vector word adds ST_NORM, ST_BIN (b shifts, b the
// binary scale), ST_MUL and ST_ADD; ST_DONE holds while the output is not free. One item at a
// time in the back unit, set by one-bit-per-cycle shifters; the queue takes items until full.
// Reset: asynchronous, clears all run state; return stack contents stay undefined.
`default_nettype none
module vector_display_list_processor_unit
  import vdlp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vdlp_in_if.sink    in_i,
  vdlp_out_if.source out_o
);
  cmd_t cmd_push, cmd_head;
  logic push, full, pop, empty;

  // front decodes the opcode field of each transfer
  vdlp_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .cmd_o  (cmd_push),
    .push_o (push)
  );

  // short queue so the input side does not wait on vector timing
  vdlp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_push),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (cmd_head),
    .empty_o (empty)
  );

  // back runs the list state, draw timer and beam arithmetic
  vdlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_valid_i (!empty),
    .cmd_pop_o   (pop),
    .out_o       (out_o)
  );
endmodule
`default_nettype wire
